[src/mpfb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared types and constants for the monochrome page framebuffer blitter:
// screen geometry, command codes, register indexes and transaction payloads.
// ----------------------------------------------------------------------------
package mpfb_pkg;

    // Screen geometry. Each byte of the store holds eight vertical pixels.
    localparam int PAGES     = 8;
    localparam int COLUMNS   = 128;
    localparam int ROWS      = PAGES * 8;
    localparam int DEPTH     = PAGES * COLUMNS;
    localparam int PAGE_W    = $clog2(PAGES);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Command codes carried in the func field.
    localparam logic [2:0] FUNC_CLEAR_AREA  = 3'd0;
    localparam logic [2:0] FUNC_INVERT_AREA = 3'd1;
    localparam logic [2:0] FUNC_BLIT_START  = 3'd2;
    localparam logic [2:0] FUNC_IMAGE_BYTE  = 3'd3;
    localparam logic [2:0] FUNC_READ_BYTE   = 3'd4;
    localparam logic [2:0] FUNC_CLEAR_ALL   = 3'd5;
    localparam logic [2:0] FUNC_INVERT_ALL  = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AREA_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 2'd3;

    // Input command transaction.
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] image_byte;
        logic [2:0] read_page;
        logic [6:0] read_column;
    } mpfb_in_t;

    // Result transaction.
    typedef struct packed {
        logic [7:0] read_data;
        logic       dropped;
    } mpfb_out_t;

endpackage

[src/mono_page_framebuffer_blitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_page_framebuffer_blitter
// One-bit-per-pixel page display store with rectangle clear and invert,
// whole-screen clear and invert, image blits with row shift, and byte reads.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                          Contents
//  in        slave      in_valid, in_ready, in_data      command transaction
//  out       master     out_valid, out_ready, out_data   one result per command
//  cfg       slave      cfg_valid, cfg_ready, cfg_index, cfg_data   area registers
//
//  After reset a clearing pass writes zero to all 1024 store bytes, one a cycle,
//  so no command is accepted until the pass ends; configuration writes are taken.
//  Every store byte modified passes a read state and then a write state on the
//  single read-modify-write path of the store. An image byte is dropped or writes
//  one or two bytes, a read passes a read and a capture state, and an area or
//  whole-screen command modifies each byte it covers. The next command is taken
//  in idle, after the result is loaded; one is accepted while a result waits, and
//  the sequencer holds its next result until the output register is free.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_blitter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mpfb_pkg::mpfb_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mpfb_pkg::mpfb_out_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mpfb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mpfb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Sequencer states.
    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_AREA_RD  = 4'd2;
    localparam logic [3:0] S_AREA_WR  = 4'd3;
    localparam logic [3:0] S_IMG_RD   = 4'd4;
    localparam logic [3:0] S_IMG_WR   = 4'd5;
    localparam logic [3:0] S_READ_RD  = 4'd6;
    localparam logic [3:0] S_READ_CAP = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    localparam int PAGE_W = mpfb_pkg::PAGE_W;
    localparam int COL_W  = mpfb_pkg::COL_W;
    localparam int ADDR_W = mpfb_pkg::ADDR_W;

    // Control state.
    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] init_addr_reg, init_addr_next;
    logic [6:0]        area_x_reg;
    logic [5:0]        area_y_reg;
    logic [7:0]        area_width_reg;
    logic [6:0]        area_height_reg;
    logic [3:0]        row_reg, row_next;
    logic [7:0]        icol_reg, icol_next;
    logic              blit_active_reg, blit_active_next;
    logic              out_valid_reg, out_valid_next;

    // Sequencer working registers.
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [PAGE_W-1:0] first_page_reg, first_page_next;
    logic [PAGE_W-1:0] last_page_reg, last_page_next;
    logic [COL_W-1:0]  first_col_reg, first_col_next;
    logic [COL_W-1:0]  last_col_reg, last_col_next;
    logic [2:0]        lo_bit_reg, lo_bit_next;
    logic [2:0]        hi_bit_reg, hi_bit_next;
    logic              inv_reg, inv_next;
    logic              second_reg, second_next;
    logic [2:0]        shift_reg, shift_next;
    logic [7:0]        byte_reg, byte_next;
    logic [7:0]        res_data_reg, res_data_next;
    logic              res_drop_reg, res_drop_next;
    mpfb_pkg::mpfb_out_t out_data_reg, out_data_next;

    // Store ports.
    logic [7:0]        frame_mem [0:mpfb_pkg::DEPTH-1];
    logic [7:0]        rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_wdata;

    // Clamped rectangle for area commands.
    logic [8:0]        x_end;
    logic [7:0]        clamp_w;
    logic [7:0]        y_end;
    logic [6:0]        clamp_h;
    logic              rect_empty;
    logic [5:0]        bottom_row;
    logic [6:0]        right_col;

    // Image cursor arithmetic.
    logic [4:0]        img_page;
    logic [8:0]        img_col;
    logic [8:0]        icol_inc;
    logic [4:0]        row_inc;
    logic [4:0]        page_rows;

    // Byte modify path.
    logic [2:0]        mask_lo;
    logic [2:0]        mask_hi;
    logic [7:0]        area_mask;
    logic [15:0]       img_shifted;
    logic              in_fire;
    logic              out_free;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Rectangle clamp against the right and bottom screen edges.
    always_comb
    begin
        x_end      = 9'(area_x_reg) + 9'(area_width_reg);
        clamp_w    = (x_end > 9'(mpfb_pkg::COLUMNS))
                     ? 8'(mpfb_pkg::COLUMNS) - 8'(area_x_reg) : area_width_reg;
        y_end      = 8'(area_y_reg) + 8'(area_height_reg);
        clamp_h    = (y_end > 8'(mpfb_pkg::ROWS))
                     ? 7'(mpfb_pkg::ROWS) - 7'(area_y_reg) : area_height_reg;
        rect_empty = (clamp_w == 8'd0) || (clamp_h == 7'd0);
        bottom_row = 6'(7'(area_y_reg) + clamp_h - 7'd1);
        right_col  = 7'(8'(area_x_reg) + clamp_w - 8'd1);
    end

    // Image cursor position and its advance.
    always_comb
    begin
        img_page  = 5'(area_y_reg[5:3]) + 5'(row_reg);
        img_col   = 9'(area_x_reg) + 9'(icol_reg);
        icol_inc  = 9'(icol_reg) + 9'd1;
        row_inc   = 5'(row_reg) + 5'd1;
        page_rows = 5'((8'(area_height_reg) + 8'd7) >> 3);
    end

    // Row mask for one page of an area command.
    always_comb
    begin
        mask_lo     = (page_reg == first_page_reg) ? lo_bit_reg : 3'd0;
        mask_hi     = (page_reg == last_page_reg) ? hi_bit_reg : 3'd7;
        area_mask   = (8'hFF << mask_lo) & (8'hFF >> (3'd7 - mask_hi));
        img_shifted = {8'h00, byte_reg} << shift_reg;
    end

    // Store port control.
    always_comb
    begin
        mem_raddr = ADDR_W'(page_reg) * ADDR_W'(mpfb_pkg::COLUMNS) + ADDR_W'(col_reg);
        mem_we    = 1'b0;
        mem_waddr = mem_raddr;
        mem_wdata = 8'h00;
        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = init_addr_reg;
            end
            S_AREA_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = inv_reg ? (rd_data_reg ^ area_mask)
                                    : (rd_data_reg & ~area_mask);
            end
            S_IMG_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg | (second_reg ? img_shifted[15:8]
                                                      : img_shifted[7:0]);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        init_addr_next   = init_addr_reg;
        row_next         = row_reg;
        icol_next        = icol_reg;
        blit_active_next = blit_active_reg;
        page_next        = page_reg;
        col_next         = col_reg;
        first_page_next  = first_page_reg;
        last_page_next   = last_page_reg;
        first_col_next   = first_col_reg;
        last_col_next    = last_col_reg;
        lo_bit_next      = lo_bit_reg;
        hi_bit_next      = hi_bit_reg;
        inv_next         = inv_reg;
        second_next      = second_reg;
        shift_next       = shift_reg;
        byte_next        = byte_reg;
        res_data_next    = res_data_reg;
        res_drop_next    = res_drop_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_data_next    = out_data_reg;

        unique case (state_reg)
            S_INIT:
            begin
                init_addr_next = init_addr_reg + ADDR_W'(1);
                if (init_addr_reg == ADDR_W'(mpfb_pkg::DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_data_next = 8'h00;
                    res_drop_next = 1'b0;
                    state_next    = S_DONE;
                    case (in_data.func) inside
                        mpfb_pkg::FUNC_CLEAR_AREA, mpfb_pkg::FUNC_INVERT_AREA,
                        mpfb_pkg::FUNC_BLIT_START:
                        begin
                            inv_next        = (in_data.func == mpfb_pkg::FUNC_INVERT_AREA);
                            first_page_next = PAGE_W'(area_y_reg[5:3]);
                            page_next       = PAGE_W'(area_y_reg[5:3]);
                            last_page_next  = PAGE_W'(bottom_row[5:3]);
                            lo_bit_next     = area_y_reg[2:0];
                            hi_bit_next     = bottom_row[2:0];
                            first_col_next  = COL_W'(area_x_reg);
                            col_next        = COL_W'(area_x_reg);
                            last_col_next   = COL_W'(right_col);
                            if (!rect_empty)
                            begin
                                state_next = S_AREA_RD;
                            end
                            if (in_data.func == mpfb_pkg::FUNC_BLIT_START)
                            begin
                                row_next         = 4'd0;
                                icol_next        = 8'd0;
                                blit_active_next = (area_width_reg != 8'd0)
                                                   && (area_height_reg != 7'd0);
                            end
                        end
                        mpfb_pkg::FUNC_CLEAR_ALL, mpfb_pkg::FUNC_INVERT_ALL:
                        begin
                            inv_next        = (in_data.func == mpfb_pkg::FUNC_INVERT_ALL);
                            first_page_next = '0;
                            page_next       = '0;
                            last_page_next  = PAGE_W'(mpfb_pkg::PAGES - 1);
                            lo_bit_next     = 3'd0;
                            hi_bit_next     = 3'd7;
                            first_col_next  = '0;
                            col_next        = '0;
                            last_col_next   = COL_W'(mpfb_pkg::COLUMNS - 1);
                            state_next      = S_AREA_RD;
                        end
                        mpfb_pkg::FUNC_IMAGE_BYTE:
                        begin
                            if (!blit_active_reg)
                            begin
                                res_drop_next = 1'b1;
                            end
                            else if (img_page >= 5'(mpfb_pkg::PAGES))
                            begin
                                blit_active_next = 1'b0;
                                res_drop_next    = 1'b1;
                            end
                            else
                            begin
                                // Advance the cursor column by column, then by page row.
                                if (icol_inc >= 9'(area_width_reg))
                                begin
                                    icol_next = 8'd0;
                                    if (row_inc >= page_rows)
                                    begin
                                        blit_active_next = 1'b0;
                                    end
                                    else
                                    begin
                                        row_next = row_inc[3:0];
                                    end
                                end
                                else
                                begin
                                    icol_next = icol_inc[7:0];
                                end
                                if (img_col >= 9'(mpfb_pkg::COLUMNS))
                                begin
                                    res_drop_next = 1'b1;
                                end
                                else
                                begin
                                    page_next   = PAGE_W'(img_page);
                                    col_next    = COL_W'(img_col);
                                    shift_next  = area_y_reg[2:0];
                                    byte_next   = in_data.image_byte;
                                    second_next = 1'b0;
                                    state_next  = S_IMG_RD;
                                end
                            end
                        end
                        mpfb_pkg::FUNC_READ_BYTE:
                        begin
                            page_next  = PAGE_W'(in_data.read_page);
                            col_next   = COL_W'(in_data.read_column);
                            state_next = S_READ_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_AREA_RD:
            begin
                state_next = S_AREA_WR;
            end

            S_AREA_WR:
            begin
                state_next = S_AREA_RD;
                if (col_reg == last_col_reg)
                begin
                    col_next = first_col_reg;
                    if (page_reg == last_page_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        page_next = page_reg + PAGE_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end

            S_IMG_RD:
            begin
                state_next = S_IMG_WR;
            end

            S_IMG_WR:
            begin
                // The spill goes to the page below unless it is off the screen.
                if (!second_reg && (shift_reg != 3'd0)
                    && (page_reg != PAGE_W'(mpfb_pkg::PAGES - 1)))
                begin
                    second_next = 1'b1;
                    page_next   = page_reg + PAGE_W'(1);
                    state_next  = S_IMG_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_READ_RD:
            begin
                state_next = S_READ_CAP;
            end

            S_READ_CAP:
            begin
                res_data_next = rd_data_reg;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.read_data = res_data_reg;
                    out_data_next.dropped   = res_drop_reg;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            init_addr_reg   <= '0;
            area_x_reg      <= 7'd0;
            area_y_reg      <= 6'd0;
            area_width_reg  <= 8'd128;
            area_height_reg <= 7'd64;
            row_reg         <= 4'd0;
            icol_reg        <= 8'd0;
            blit_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            init_addr_reg   <= init_addr_next;
            row_reg         <= row_next;
            icol_reg        <= icol_next;
            blit_active_reg <= blit_active_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    mpfb_pkg::REG_AREA_X:      area_x_reg      <= cfg_data[6:0];
                    mpfb_pkg::REG_AREA_Y:      area_y_reg      <= cfg_data[5:0];
                    mpfb_pkg::REG_AREA_WIDTH:  area_width_reg  <= cfg_data[7:0];
                    mpfb_pkg::REG_AREA_HEIGHT: area_height_reg <= cfg_data[6:0];
                    default:                   area_x_reg      <= area_x_reg;
                endcase
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        page_reg       <= page_next;
        col_reg        <= col_next;
        first_page_reg <= first_page_next;
        last_page_reg  <= last_page_next;
        first_col_reg  <= first_col_next;
        last_col_reg   <= last_col_next;
        lo_bit_reg     <= lo_bit_next;
        hi_bit_reg     <= hi_bit_next;
        inv_reg        <= inv_next;
        second_reg     <= second_next;
        shift_reg      <= shift_next;
        byte_reg       <= byte_next;
        res_data_reg   <= res_data_next;
        res_drop_reg   <= res_drop_next;
        out_data_reg   <= out_data_next;
    end

    // Display store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= frame_mem[mem_raddr];
    end

    // The store is never written while the sequencer waits for a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) || (state_reg == S_DONE) |-> !mem_we)
        else $error("store written outside a command");

    // A dropped image byte never carries read data.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.dropped |-> (out_data.read_data == 8'h00))
        else $error("dropped result carries data");

    // The block is busy in the cycle after a command transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("command accepted on consecutive cycles");

    // A blit opens only on a blit start command.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(blit_active_reg) |->
            $past(in_fire && (in_data.func == mpfb_pkg::FUNC_BLIT_START)))
        else $error("blit opened without a blit start");

    // A new result is loaded only once the previous one has been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && out_valid_reg && !out_ready |=> (state_reg == S_DONE))
        else $error("result overwritten before it was taken");

endmodule
